>>> rtl/counting_multiset_table_unit_macros.svh
// assertion macros for the counting multiset table checker
`ifndef COUNTING_MULTISET_TABLE_UNIT_MACROS_SVH
`define COUNTING_MULTISET_TABLE_UNIT_MACROS_SVH

// checked only outside reset
`define CMST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define CMST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/cmst_pkg.sv
// types and constants shared by the counting multiset table modules
package cmst_pkg;

    localparam int OPCODE_W    = 3;
    localparam int KEY_IN_W    = 32;
    localparam int RANK_W      = 5;
    localparam int QTY_W       = 16;
    localparam int KEY_OUT_W   = 32;
    localparam int TOTAL_W     = 21;
    localparam int DISTINCT_W  = 6;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 80;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT    = 3'd0,
        OP_ERASE_ONE = 3'd1,
        OP_ERASE_ALL = 3'd2,
        OP_COUNT     = 3'd3,
        OP_GET       = 3'd4
    } op_e_t;

    // control part of the command token walking the cell chain
    typedef struct packed {
        logic  valid;
        op_e_t op;
        logic  hit;
        logic  ok;
        logic  zeroed;
        logic  has_empty;
    } cmst_ctl_t;

endpackage

>>> rtl/cmst_cell.sv
// one slot of the table: key and count, updated as the command token passes
module cmst_cell
    import cmst_pkg::*;
#(
    parameter int KEY_WIDTH   = 32,
    parameter int COUNT_WIDTH = 16,
    parameter int IDX_W       = 5,
    parameter int SEEN_W      = 6,
    parameter int IDX         = 0
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cmst_ctl_t              ctl_i,
    input  logic [KEY_WIDTH-1:0]   key_i,
    input  logic [RANK_W-1:0]      rank_i,
    input  logic [SEEN_W-1:0]      seen_i,
    input  logic [COUNT_WIDTH-1:0] qty_i,
    input  logic [KEY_WIDTH-1:0]   kout_i,
    input  logic [IDX_W-1:0]       eidx_i,
    input  logic                   claim_en_i,
    input  logic [IDX_W-1:0]       claim_idx_i,
    input  logic [KEY_WIDTH-1:0]   claim_key_i,
    output cmst_ctl_t              ctl_o,
    output logic [KEY_WIDTH-1:0]   key_o,
    output logic [RANK_W-1:0]      rank_o,
    output logic [SEEN_W-1:0]      seen_o,
    output logic [COUNT_WIDTH-1:0] qty_o,
    output logic [KEY_WIDTH-1:0]   kout_o,
    output logic [IDX_W-1:0]       eidx_o
);

    localparam int CMP_W = (SEEN_W > RANK_W) ? SEEN_W : RANK_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [KEY_WIDTH-1:0]   slot_key_reg;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    cmst_ctl_t              ctl_reg, ctl_next;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [RANK_W-1:0]      rank_reg;
    logic [SEEN_W-1:0]      seen_reg, seen_next;
    logic [COUNT_WIDTH-1:0] qty_reg, qty_next;
    logic [KEY_WIDTH-1:0]   kout_reg, kout_next;
    logic [IDX_W-1:0]       eidx_reg, eidx_next;
    logic                   occupied, match, at_max, claim_hit;

    assign occupied  = (cnt_reg != '0);
    assign match     = occupied && (slot_key_reg == key_i);
    assign at_max    = (cnt_reg == COUNT_MAX);
    assign claim_hit = claim_en_i && (claim_idx_i == MY_IDX);

    always_comb begin
        ctl_next  = ctl_i;
        seen_next = seen_i;
        qty_next  = qty_i;
        kout_next = kout_i;
        eidx_next = eidx_i;
        cnt_next  = cnt_reg;
        if (ctl_i.valid && !ctl_i.hit) begin
            case (ctl_i.op)
                OP_INSERT: begin
                    if (match) begin
                        ctl_next.hit = 1'b1;
                        if (!at_max) begin
                            cnt_next    = cnt_reg + 1'b1;
                            ctl_next.ok = 1'b1;
                        end
                        qty_next = cnt_next;
                    end else if (!occupied && !ctl_i.has_empty) begin
                        ctl_next.has_empty = 1'b1;
                        eidx_next          = MY_IDX;
                    end
                end
                OP_ERASE_ONE: begin
                    if (match) begin
                        ctl_next.hit    = 1'b1;
                        ctl_next.ok     = 1'b1;
                        ctl_next.zeroed = (cnt_reg == COUNT_WIDTH'(1));
                        cnt_next        = cnt_reg - 1'b1;
                        qty_next        = COUNT_WIDTH'(1);
                    end
                end
                OP_ERASE_ALL: begin
                    if (match) begin
                        ctl_next.hit = 1'b1;
                        ctl_next.ok  = 1'b1;
                        qty_next     = cnt_reg;
                        cnt_next     = '0;
                    end
                end
                OP_COUNT: begin
                    if (match) begin
                        ctl_next.hit = 1'b1;
                        ctl_next.ok  = 1'b1;
                        qty_next     = cnt_reg;
                    end
                end
                OP_GET: begin
                    if (occupied) begin
                        if (CMP_W'(seen_i) == CMP_W'(rank_i)) begin
                            ctl_next.hit = 1'b1;
                            ctl_next.ok  = 1'b1;
                            qty_next     = cnt_reg;
                            kout_next    = slot_key_reg;
                        end else begin
                            seen_next = seen_i + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (claim_hit) begin
            cnt_next = COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            ctl_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (claim_hit) begin
            slot_key_reg <= claim_key_i;
        end
        key_reg  <= key_i;
        rank_reg <= rank_i;
        seen_reg <= seen_next;
        qty_reg  <= qty_next;
        kout_reg <= kout_next;
        eidx_reg <= eidx_next;
    end

    assign ctl_o  = ctl_reg;
    assign key_o  = key_reg;
    assign rank_o = rank_reg;
    assign seen_o = seen_reg;
    assign qty_o  = qty_reg;
    assign kout_o = kout_reg;
    assign eidx_o = eidx_reg;

endmodule

>>> rtl/counting_multiset_table_unit.sv
// top level of the counting multiset table: command intake, cell chain and result register
//
// A table of SLOTS key/count cells holds a multiset. Each command (insert, erase one,
// erase all, count, get by rank) enters the head of the cell chain as a token and moves
// one cell per cycle, each cell matching and updating its own slot as the token passes.
// The token is captured at the chain tail when it leaves the last cell; a claim of
// the lowest empty slot for a new key and the running totals are applied as the result
// is loaded. The next command word is taken in the cycle after that, so the block takes
// no new command until the last result is loaded. A waiting result does not block the
// next command's intake, but holds back its result until the waiting word is taken.
module counting_multiset_table_unit
    import cmst_pkg::*;
#(
    parameter int SLOTS       = 32,
    parameter int KEY_WIDTH   = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // opcode, key_in, rank
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // ok, quantity, key_out, total_items, distinct_items
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int SEEN_W = $clog2(SLOTS + 1);
    localparam int TW     = COUNT_WIDTH + IDX_W;
    localparam int OW     = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    cmst_ctl_t              ctl_w  [SLOTS+1];
    logic [KEY_WIDTH-1:0]   key_w  [SLOTS+1];
    logic [RANK_W-1:0]      rank_w [SLOTS+1];
    logic [SEEN_W-1:0]      seen_w [SLOTS+1];
    logic [COUNT_WIDTH-1:0] qty_w  [SLOTS+1];
    logic [KEY_WIDTH-1:0]   kout_w [SLOTS+1];
    logic [IDX_W-1:0]       eidx_w [SLOTS+1];

    cmst_ctl_t              fin_ctl_reg;
    logic [KEY_WIDTH-1:0]   fin_key_reg;
    logic [COUNT_WIDTH-1:0] fin_qty_reg;
    logic [KEY_WIDTH-1:0]   fin_kout_reg;
    logic [IDX_W-1:0]       fin_eidx_reg;

    logic [TW-1:0]          total_reg, total_next;
    logic [OW-1:0]          occ_reg, occ_next;

    logic                   m_valid_reg;
    logic                   res_ok_reg;
    logic [COUNT_WIDTH-1:0] res_qty_reg;
    logic [KEY_WIDTH-1:0]   res_kout_reg;

    logic                   accept, commit, claim, res_ok;
    logic [COUNT_WIDTH-1:0] res_qty;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign commit   = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    // chain head
    always_comb begin
        ctl_w[0]       = '0;
        ctl_w[0].valid = accept;
        ctl_w[0].op    = op_e_t'(s_tdata[2:0]);
    end
    assign key_w[0]  = KEY_WIDTH'(s_tdata[34:3]);
    assign rank_w[0] = s_tdata[39:35];
    assign seen_w[0] = '0;
    assign qty_w[0]  = '0;
    assign kout_w[0] = '0;
    assign eidx_w[0] = '0;

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        cmst_cell #(
            .KEY_WIDTH   (KEY_WIDTH),
            .COUNT_WIDTH (COUNT_WIDTH),
            .IDX_W       (IDX_W),
            .SEEN_W      (SEEN_W),
            .IDX         (i)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl_i       (ctl_w[i]),
            .key_i       (key_w[i]),
            .rank_i      (rank_w[i]),
            .seen_i      (seen_w[i]),
            .qty_i       (qty_w[i]),
            .kout_i      (kout_w[i]),
            .eidx_i      (eidx_w[i]),
            .claim_en_i  (claim),
            .claim_idx_i (fin_eidx_reg),
            .claim_key_i (fin_key_reg),
            .ctl_o       (ctl_w[i+1]),
            .key_o       (key_w[i+1]),
            .rank_o      (rank_w[i+1]),
            .seen_o      (seen_w[i+1]),
            .qty_o       (qty_w[i+1]),
            .kout_o      (kout_w[i+1]),
            .eidx_o      (eidx_w[i+1])
        );
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_RUN;
            ST_RUN:  if (ctl_w[SLOTS].valid) state_next = ST_DONE;
            ST_DONE: if (commit) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign claim   = commit && (fin_ctl_reg.op == OP_INSERT) && !fin_ctl_reg.hit
                     && fin_ctl_reg.has_empty;
    assign res_ok  = fin_ctl_reg.ok || claim;
    assign res_qty = claim ? COUNT_WIDTH'(1) : fin_qty_reg;

    always_comb begin
        total_next = total_reg;
        occ_next   = occ_reg;
        if (commit && res_ok) begin
            case (fin_ctl_reg.op)
                OP_INSERT: begin
                    total_next = total_reg + 1'b1;
                    if (claim) occ_next = occ_reg + 1'b1;
                end
                OP_ERASE_ONE: begin
                    total_next = total_reg - 1'b1;
                    if (fin_ctl_reg.zeroed) occ_next = occ_reg - 1'b1;
                end
                OP_ERASE_ALL: begin
                    total_next = total_reg - TW'(fin_qty_reg);
                    occ_next   = occ_reg - 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fin_ctl_reg <= '0;
            total_reg   <= '0;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            total_reg <= total_next;
            occ_reg   <= occ_next;
            if (ctl_w[SLOTS].valid) begin
                fin_ctl_reg <= ctl_w[SLOTS];
            end
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_w[SLOTS].valid) begin
            fin_key_reg  <= key_w[SLOTS];
            fin_qty_reg  <= qty_w[SLOTS];
            fin_kout_reg <= kout_w[SLOTS];
            fin_eidx_reg <= eidx_w[SLOTS];
        end
        if (commit) begin
            res_ok_reg   <= res_ok;
            res_qty_reg  <= res_qty;
            res_kout_reg <= fin_kout_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, DISTINCT_W'(occ_reg), TOTAL_W'(total_reg),
                       KEY_OUT_W'(res_kout_reg), QTY_W'(res_qty_reg), res_ok_reg};

endmodule

>>> rtl/cmst_checker.sv
// port-level checker for the counting multiset table and its bind
`include "counting_multiset_table_unit_macros.svh"

module cmst_checker
    import cmst_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    `CMST_ASSERT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "second command word taken while one is in flight")
    `CMST_ASSERT(a_no_instant_result, aclk, aresetn, s_tvalid && s_tready |=> !$rose(m_tvalid), "result word right after command word")
    `CMST_ASSERT(a_fail_no_key, aclk, aresetn, m_tvalid && !m_tdata[0] |-> m_tdata[48:17] == 32'd0, "key_out nonzero on a failed result")
    `CMST_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result word changed")
    `CMST_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid && s_tready, "output not empty after reset")

endmodule

bind counting_multiset_table_unit cmst_checker u_cmst_checker (.*);
